### src/epfg_pkg.sv
// Shared types, constants and helper functions of the EEG packet deframer.
// No dependencies; every file of the block but epfg_ram takes names from here.
package epfg_pkg;

  localparam int MAX_CHANNELS = 32;
  localparam int RING_SLOTS   = 4;

  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W      = $clog2(MAX_CHANNELS + 1);
  localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int RING_DEPTH = RING_SLOTS * MAX_CHANNELS;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 5;
  localparam int CCOUNT_W   = 6;
  localparam int FILL_W     = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam int HI_SHIFT  = 24;
  localparam int MID_SHIFT = 17;
  localparam int LO_SHIFT  = 10;

  localparam logic [BYTE_W-1:0]   SYNC_BYTE        = 8'hFF;
  localparam logic [BYTE_W-1:0]   STATUS_STRIP     = 8'h11;
  localparam logic [BYTE_W-1:0]   STATUS_KEEP      = 8'h10;
  localparam logic [CCOUNT_W-1:0] DEFAULT_CHANNELS = 6'd24;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP         = 8'd1;

  localparam logic [1:0] GRP_HIGH = 2'd0;
  localparam logic [1:0] GRP_MID  = 2'd1;
  localparam logic [1:0] GRP_LOW  = 2'd2;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_POLL = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    PH_SEEK    = 2'd0,
    PH_COUNTER = 2'd1,
    PH_DATA    = 2'd2,
    PH_STATUS  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_LIVE   = 2'd0,
    KIND_REPLAY = 2'd1,
    KIND_FILL   = 2'd2
  } kind_t;

  // Everything of a result item except the channel word, which comes from memory.
  typedef struct packed {
    logic             carries;
    kind_t            kind;
    logic [IDX_W-1:0] index;
    logic             last;
    logic             more;
    logic             dropped;
  } res_t;

  // Request to copy the staged sample into one ring slot.
  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } copy_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CCOUNT_W-1:0] cc);
    logic [CNT_W-1:0] n;
    if (cc == '0) begin
      n = CNT_W'(1);
    end else if (int'(cc) > MAX_CHANNELS) begin
      n = CNT_W'(MAX_CHANNELS);
    end else begin
      n = CNT_W'(cc);
    end
    return n;
  endfunction

  function automatic logic [RING_AW-1:0] ring_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [CH_W-1:0]   idx);
    return RING_AW'(int'(slot) * MAX_CHANNELS + int'(idx));
  endfunction

endpackage

### src/epfg_if.sv
// Handshake interfaces of the deframer: input items, result items and
// configuration writes. Depends on epfg_pkg for field widths.
interface epfg_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [epfg_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface epfg_out_if;
  logic                              valid;
  logic                              ready;
  logic                              valid_res;
  logic signed [epfg_pkg::WORD_W-1:0] channel_value;
  logic [epfg_pkg::IDX_W-1:0]        channel_index;
  logic                              last_channel;
  logic [1:0]                        sample_kind;
  logic                              more_pending;
  logic                              byte_dropped;

  modport source (output valid, output valid_res, output channel_value,
                  output channel_index, output last_channel, output sample_kind,
                  output more_pending, output byte_dropped, input ready);
  modport sink   (input valid, input valid_res, input channel_value,
                  input channel_index, input last_channel, input sample_kind,
                  input more_pending, input byte_dropped, output ready);
endinterface

interface epfg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [epfg_pkg::CFG_IDX_W-1:0]  index;
  logic [epfg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/eeg_packet_deframer_gap_fill.sv
// EEG packet deframer with gap filling. One item (a serial byte or a poll) can
// be accepted on every clock while in_ch.ready allows; its result passes the
// read stage and then the output register on its way to the output channel;
// the read stage can take one more item while a result waits at the output.
// The staged sample and the four-slot replay ring live in synchronous RAMs.
// After a good status byte, a background copy of the staged sample into its ring
// slot reads one channel per cycle unless a poll takes the staging read port or
// a stalled result holds the read data, and writes each channel into the ring
// in the cycle after its read. While the copy runs, items are taken only while
// the live sample is the next to be read out; with no words queued, or with
// filler samples queued ahead of it, new items are held off until the copy has
// finished. The ring has a written flag per entry, so there is no clearing pass
// after reset.
// Depends on epfg_pkg, epfg_if, epfg_ram, epfg_ctrl, epfg_copy and epfg_out.
module eeg_packet_deframer_gap_fill (
  input  logic         clk,
  input  logic         rst_n,
  epfg_in_if.sink      in_ch,
  epfg_out_if.source   out_ch,
  epfg_cfg_if.sink     cfg_ch
);

  logic [epfg_pkg::CCOUNT_W-1:0] channel_count_r;
  logic                          strip_impedance_r;

  logic                          in_accept;
  logic                          pending;
  logic                          ring_due;
  logic                          copy_busy;
  logic                          out_free;
  logic                          out_hold;
  epfg_pkg::res_t                res;
  epfg_pkg::copy_t               copy;

  logic                          stg_we;
  logic [epfg_pkg::CH_W-1:0]     stg_waddr;
  logic [epfg_pkg::WORD_W-1:0]   stg_wdata;
  logic                          poll_stg_rd;
  logic [epfg_pkg::CH_W-1:0]     poll_stg_addr;
  logic                          copy_stg_rd;
  logic [epfg_pkg::CH_W-1:0]     copy_stg_addr;
  logic [epfg_pkg::WORD_W-1:0]   stg_rdata;

  logic                          ring_rd_en;
  logic [epfg_pkg::RING_AW-1:0]  ring_raddr;
  logic                          ring_we;
  logic [epfg_pkg::RING_AW-1:0]  ring_waddr;
  logic [epfg_pkg::WORD_W-1:0]   ring_rdata;
  logic                          ring_vld;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r   <= epfg_pkg::DEFAULT_CHANNELS;
      strip_impedance_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        epfg_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_ch.data[epfg_pkg::CCOUNT_W-1:0];
        epfg_pkg::REG_STRIP:         strip_impedance_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // While the ring copy runs, only readout of the live sample (and bytes dropped
  // beside it) may proceed; filler and replay words must see the finished copy.
  assign in_ch.ready = out_free && !(copy_busy && (!pending || ring_due));
  assign in_accept   = in_ch.valid && in_ch.ready;

  epfg_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .opcode          (in_ch.opcode),
    .rx_byte         (in_ch.rx_byte),
    .channel_count   (channel_count_r),
    .strip_impedance (strip_impedance_r),
    .res             (res),
    .pending         (pending),
    .ring_due        (ring_due),
    .stg_we          (stg_we),
    .stg_waddr       (stg_waddr),
    .stg_wdata       (stg_wdata),
    .stg_rd_en       (poll_stg_rd),
    .stg_raddr       (poll_stg_addr),
    .ring_rd_en      (ring_rd_en),
    .ring_raddr      (ring_raddr),
    .copy            (copy)
  );

  epfg_copy u_copy (
    .clk        (clk),
    .rst_n      (rst_n),
    .copy       (copy),
    .port_taken (poll_stg_rd),
    .hold       (out_hold),
    .ring_rd_en (ring_rd_en),
    .ring_raddr (ring_raddr),
    .stg_rd_en  (copy_stg_rd),
    .stg_raddr  (copy_stg_addr),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_vld   (ring_vld),
    .busy       (copy_busy)
  );

  epfg_ram #(
    .WIDTH (epfg_pkg::WORD_W),
    .DEPTH (epfg_pkg::MAX_CHANNELS)
  ) u_staging (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (stg_wdata),
    .re    (poll_stg_rd || copy_stg_rd),
    .raddr (poll_stg_rd ? poll_stg_addr : copy_stg_addr),
    .rdata (stg_rdata)
  );

  epfg_ram #(
    .WIDTH (epfg_pkg::WORD_W),
    .DEPTH (epfg_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (stg_rdata),
    .re    (ring_rd_en),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  epfg_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .res        (res),
    .stg_rdata  (stg_rdata),
    .ring_rdata (ring_rdata),
    .ring_vld   (ring_vld),
    .free       (out_free),
    .hold       (out_hold),
    .out_ch     (out_ch)
  );

`ifndef ASSERT_OFF
  a_no_parse_during_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && copy_busy) |-> pending)
    else $error("item accepted into the parser while the ring copy runs");

  a_ring_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_we && ring_rd_en) |-> (ring_waddr != ring_raddr))
    else $error("ring entry read while the copy writes it");

  a_ring_read_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
    ring_rd_en |-> !copy_busy)
    else $error("ring read while the copy into it runs");

  a_staging_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    stg_we |-> (!pending && !copy_busy))
    else $error("staging written while its sample is still in use");

  a_copy_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    copy.start |-> !copy_busy)
    else $error("ring copy started while the previous one runs");
`endif

endmodule

### src/epfg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module epfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/epfg_ctrl.sv
// Packet parser and readout sequencer: holds the control state, writes the
// staging memory and issues reads for polled words. Depends on epfg_pkg.
module epfg_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            opcode,
  input  logic [epfg_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [epfg_pkg::CCOUNT_W-1:0]   channel_count,
  input  logic                            strip_impedance,
  output epfg_pkg::res_t                  res,
  output logic                            pending,
  output logic                            ring_due,
  output logic                            stg_we,
  output logic [epfg_pkg::CH_W-1:0]       stg_waddr,
  output logic [epfg_pkg::WORD_W-1:0]     stg_wdata,
  output logic                            stg_rd_en,
  output logic [epfg_pkg::CH_W-1:0]       stg_raddr,
  output logic                            ring_rd_en,
  output logic [epfg_pkg::RING_AW-1:0]    ring_raddr,
  output epfg_pkg::copy_t                 copy
);

  epfg_pkg::phase_t                phase_r, phase_nxt;
  logic [epfg_pkg::BYTE_W-1:0]     last_cnt_r, last_cnt_nxt;
  logic [epfg_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [epfg_pkg::CNT_W-1:0]      cursor_r, cursor_nxt;
  logic [1:0]                      grp_r, grp_nxt;
  logic [epfg_pkg::BYTE_W-1:0]     hi_r, hi_nxt;
  logic [epfg_pkg::BYTE_W-1:0]     mid_r, mid_nxt;
  logic [epfg_pkg::FILL_W-1:0]     fill_r, fill_nxt;
  logic                            final_r, final_nxt;
  logic                            from_ring_r, from_ring_nxt;
  logic [epfg_pkg::CH_W-1:0]       emit_r, emit_nxt;

  logic [epfg_pkg::CNT_W-1:0]      n;
  logic                            is_byte;
  logic                            parse_en;
  logic                            emit_en;
  logic                            status_good;
  logic [epfg_pkg::CNT_W-1:0]      cursor_inc;
  logic                            data_last;
  logic [epfg_pkg::CNT_W-1:0]      emit_inc;
  logic                            emit_last;
  logic [epfg_pkg::BYTE_W-1:0]     gap;

  assign n           = epfg_pkg::eff_count(channel_count);
  assign pending     = (fill_r != '0) || final_r;
  // The next word to be read out comes from the replay ring.
  assign ring_due    = pending && ((fill_r != '0) || from_ring_r);
  assign is_byte     = (opcode == epfg_pkg::OP_BYTE);
  assign parse_en    = accept && is_byte && !pending;
  assign emit_en     = accept && !is_byte && pending;
  assign status_good = rx_byte == (strip_impedance ? epfg_pkg::STATUS_STRIP
                                                   : epfg_pkg::STATUS_KEEP);
  assign cursor_inc  = cursor_r + epfg_pkg::CNT_W'(1);
  assign data_last   = cursor_inc >= n;
  assign emit_inc    = epfg_pkg::CNT_W'(emit_r) + epfg_pkg::CNT_W'(1);
  assign emit_last   = emit_inc >= n;
  assign gap         = rx_byte - last_cnt_r - epfg_pkg::BYTE_W'(1);

  // Next parse phase.
  always_comb begin
    phase_nxt = phase_r;
    if (parse_en) begin
      unique case (phase_r)
        epfg_pkg::PH_SEEK: begin
          if (rx_byte == epfg_pkg::SYNC_BYTE) begin
            phase_nxt = epfg_pkg::PH_COUNTER;
          end
        end
        epfg_pkg::PH_COUNTER: phase_nxt = epfg_pkg::PH_DATA;
        epfg_pkg::PH_DATA: begin
          if (grp_r == epfg_pkg::GRP_LOW && data_last) begin
            phase_nxt = epfg_pkg::PH_STATUS;
          end
        end
        epfg_pkg::PH_STATUS: phase_nxt = epfg_pkg::PH_SEEK;
        default: phase_nxt = epfg_pkg::PH_SEEK;
      endcase
    end
  end

  // Datapath, memory requests and result fields.
  always_comb begin
    last_cnt_nxt  = last_cnt_r;
    slot_nxt      = slot_r;
    cursor_nxt    = cursor_r;
    grp_nxt       = grp_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    fill_nxt      = fill_r;
    final_nxt     = final_r;
    from_ring_nxt = from_ring_r;
    emit_nxt      = emit_r;
    res           = '0;
    copy.start    = 1'b0;
    copy.slot     = slot_r;
    copy.count    = n;
    stg_we        = 1'b0;
    // A cursor past the store wraps to entry zero.
    stg_waddr     = (int'(cursor_r) < epfg_pkg::MAX_CHANNELS) ?
                    cursor_r[epfg_pkg::CH_W-1:0] : '0;
    stg_wdata     = (epfg_pkg::WORD_W'(hi_r)    << epfg_pkg::HI_SHIFT)  |
                    (epfg_pkg::WORD_W'(mid_r)   << epfg_pkg::MID_SHIFT) |
                    (epfg_pkg::WORD_W'(rx_byte) << epfg_pkg::LO_SHIFT);
    stg_rd_en     = 1'b0;
    stg_raddr     = emit_r;
    ring_rd_en    = 1'b0;
    ring_raddr    = epfg_pkg::ring_addr(slot_r, emit_r);

    if (accept && is_byte && pending) begin
      res.dropped = 1'b1;
      res.more    = 1'b1;
    end else if (parse_en) begin
      unique case (phase_r)
        epfg_pkg::PH_SEEK: ;
        epfg_pkg::PH_COUNTER: begin
          fill_nxt     = gap[epfg_pkg::FILL_W-1:0];
          last_cnt_nxt = rx_byte;
          cursor_nxt   = '0;
          grp_nxt      = epfg_pkg::GRP_HIGH;
        end
        epfg_pkg::PH_DATA: begin
          case (grp_r)
            epfg_pkg::GRP_HIGH: begin
              hi_nxt  = rx_byte;
              grp_nxt = epfg_pkg::GRP_MID;
            end
            epfg_pkg::GRP_MID: begin
              mid_nxt = rx_byte;
              grp_nxt = epfg_pkg::GRP_LOW;
            end
            default: begin
              stg_we     = 1'b1;
              grp_nxt    = epfg_pkg::GRP_HIGH;
              cursor_nxt = cursor_inc;
            end
          endcase
        end
        epfg_pkg::PH_STATUS: begin
          copy.start    = status_good;
          from_ring_nxt = !status_good;
          final_nxt     = 1'b1;
          emit_nxt      = '0;
        end
        default: ;
      endcase
      res.more = (fill_nxt != '0) || final_nxt;
    end else if (emit_en) begin
      res.carries = 1'b1;
      res.index   = epfg_pkg::IDX_W'(emit_r);
      res.last    = emit_last;
      if (fill_r != '0) begin
        res.kind = epfg_pkg::KIND_FILL;
      end else if (from_ring_r) begin
        res.kind = epfg_pkg::KIND_REPLAY;
      end else begin
        res.kind = epfg_pkg::KIND_LIVE;
      end
      stg_rd_en  = (res.kind == epfg_pkg::KIND_LIVE);
      ring_rd_en = (res.kind != epfg_pkg::KIND_LIVE);
      if (emit_last) begin
        emit_nxt = '0;
        slot_nxt = (slot_r == epfg_pkg::SLOT_W'(epfg_pkg::RING_SLOTS - 1)) ?
                   '0 : slot_r + epfg_pkg::SLOT_W'(1);
        if (fill_r != '0) begin
          fill_nxt = fill_r - epfg_pkg::FILL_W'(1);
        end else begin
          final_nxt = 1'b0;
        end
      end else begin
        emit_nxt = emit_inc[epfg_pkg::CH_W-1:0];
      end
      res.more = (fill_nxt != '0) || final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= epfg_pkg::PH_SEEK;
      last_cnt_r  <= '0;
      slot_r      <= '0;
      cursor_r    <= '0;
      grp_r       <= epfg_pkg::GRP_HIGH;
      hi_r        <= '0;
      mid_r       <= '0;
      fill_r      <= '0;
      final_r     <= 1'b0;
      from_ring_r <= 1'b0;
      emit_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      last_cnt_r  <= last_cnt_nxt;
      slot_r      <= slot_nxt;
      cursor_r    <= cursor_nxt;
      grp_r       <= grp_nxt;
      hi_r        <= hi_nxt;
      mid_r       <= mid_nxt;
      fill_r      <= fill_nxt;
      final_r     <= final_nxt;
      from_ring_r <= from_ring_nxt;
      emit_r      <= emit_nxt;
    end
  end

endmodule

### src/epfg_copy.sv
// Background copy of a staged good sample into its ring slot, plus the
// written-flags of the ring entries. Depends on epfg_pkg.
module epfg_copy (
  input  logic                           clk,
  input  logic                           rst_n,
  input  epfg_pkg::copy_t                copy,
  input  logic                           port_taken,
  input  logic                           hold,
  input  logic                           ring_rd_en,
  input  logic [epfg_pkg::RING_AW-1:0]   ring_raddr,
  output logic                           stg_rd_en,
  output logic [epfg_pkg::CH_W-1:0]      stg_raddr,
  output logic                           ring_we,
  output logic [epfg_pkg::RING_AW-1:0]   ring_waddr,
  output logic                           ring_vld,
  output logic                           busy
);

  logic                              active_r, active_nxt;
  logic [epfg_pkg::SLOT_W-1:0]       slot_r, slot_nxt;
  logic [epfg_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [epfg_pkg::CH_W-1:0]         idx_r, idx_nxt;
  logic                              wr_pend_r, wr_pend_nxt;
  logic [epfg_pkg::RING_AW-1:0]      wr_addr_r, wr_addr_nxt;
  logic [epfg_pkg::RING_DEPTH-1:0]   written_r;
  logic                              vld_rd_r;
  logic                              rd_go;
  logic [epfg_pkg::CNT_W-1:0]        idx_inc;

  // The staging read port belongs to polls first; the copy also waits while
  // the read data of a stalled result must stay put.
  assign rd_go      = active_r && !port_taken && !hold;
  assign idx_inc    = epfg_pkg::CNT_W'(idx_r) + epfg_pkg::CNT_W'(1);
  assign stg_rd_en  = rd_go;
  assign stg_raddr  = idx_r;
  assign ring_we    = wr_pend_r;
  assign ring_waddr = wr_addr_r;
  assign ring_vld   = vld_rd_r;
  assign busy       = active_r || wr_pend_r;

  always_comb begin
    active_nxt  = active_r;
    slot_nxt    = slot_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    wr_pend_nxt = rd_go;
    wr_addr_nxt = epfg_pkg::ring_addr(slot_r, idx_r);
    if (copy.start) begin
      active_nxt = 1'b1;
      slot_nxt   = copy.slot;
      count_nxt  = copy.count;
      idx_nxt    = '0;
    end else if (rd_go) begin
      if (idx_inc >= count_r) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_inc[epfg_pkg::CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      wr_pend_r <= 1'b0;
      written_r <= '0;
      vld_rd_r  <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      wr_pend_r <= wr_pend_nxt;
      if (wr_pend_r) begin
        written_r[wr_addr_r] <= 1'b1;
      end
      if (ring_rd_en) begin
        vld_rd_r <= written_r[ring_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    count_r   <= count_nxt;
    idx_r     <= idx_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

endmodule

### src/epfg_out.sv
// Result path: a stage that waits for the memory read data, then the output
// register towards the result channel. Depends on epfg_pkg and epfg_if.
module epfg_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  epfg_pkg::res_t              res,
  input  logic [epfg_pkg::WORD_W-1:0] stg_rdata,
  input  logic [epfg_pkg::WORD_W-1:0] ring_rdata,
  input  logic                        ring_vld,
  output logic                        free,
  output logic                        hold,
  epfg_out_if.source                  out_ch
);

  logic                        s1_valid_r, s1_valid_nxt;
  epfg_pkg::res_t              s1_res_r;
  logic                        o_valid_r, o_valid_nxt;
  epfg_pkg::res_t              o_res_r;
  logic [epfg_pkg::WORD_W-1:0] o_value_r;
  logic [epfg_pkg::WORD_W-1:0] value;
  logic                        s1_adv;

  assign s1_adv = !o_valid_r || out_ch.ready;
  assign free   = !s1_valid_r || s1_adv;
  assign hold   = s1_valid_r && !s1_adv;

  // Ring entries never written since reset read as zero.
  always_comb begin
    if (!s1_res_r.carries) begin
      value = '0;
    end else if (s1_res_r.kind == epfg_pkg::KIND_LIVE) begin
      value = stg_rdata;
    end else begin
      value = ring_vld ? ring_rdata : '0;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    o_valid_nxt  = o_valid_r;
    if (s1_adv) begin
      o_valid_nxt  = s1_valid_r;
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
    end
    if (s1_valid_r && s1_adv) begin
      o_res_r   <= s1_res_r;
      o_value_r <= value;
    end
  end

  assign out_ch.valid         = o_valid_r;
  assign out_ch.valid_res     = o_res_r.carries;
  assign out_ch.channel_value = o_value_r;
  assign out_ch.channel_index = o_res_r.index;
  assign out_ch.last_channel  = o_res_r.last;
  assign out_ch.sample_kind   = o_res_r.kind;
  assign out_ch.more_pending  = o_res_r.more;
  assign out_ch.byte_dropped  = o_res_r.dropped;

`ifndef ASSERT_OFF
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item did not reach the read stage");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> free)
    else $error("item accepted while the read stage could not move");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for eeg_packet_deframer_gap_fill: serial EEG packets
// and polls go in, each result item is checked against an in-bench predictor.
// Depends on epfg_pkg, the epfg interfaces and the block itself.
module tb_top;

  localparam int GEN_COPY  = 0;  // predictor copy that runs ahead with stimulus generation
  localparam int CHK_COPY  = 1;  // predictor copy that advances on accepted items
  localparam int IDLE_GAP  = 48; // covers output latency and the ring copy
  localparam int PHASE_LEN = 60;

  typedef struct packed {
    epfg_pkg::opcode_t op;
    logic [7:0]        b;
  } rx_item_t;

  typedef struct packed {
    logic            carries;
    logic [31:0]     value;
    logic [4:0]      index;
    logic            last;
    epfg_pkg::kind_t kind;
    logic            more;
    logic            dropped;
  } chan_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              src_valid = 1'b0;
  epfg_pkg::opcode_t src_op = epfg_pkg::OP_BYTE;
  logic [7:0]        src_byte = 8'h00;
  logic              sink_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [epfg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [epfg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int item_count = 0;

  rx_item_t   rx_items[$];
  rx_item_t   shown_item;
  chan_word_t exp_words[$];

  // Register copies; written only while the block is idle, so one set serves both copies.
  logic [5:0] cc_val = epfg_pkg::DEFAULT_CHANNELS;
  logic       strip_val = 1'b0;

  epfg_pkg::phase_t parse_ph [2];
  logic [7:0]  last_cnt [2];
  int          slot_pos [2];
  int          chan_pos [2];
  int          emit_pos [2];
  logic [1:0]  grp_pos [2];
  logic [7:0]  hi_b [2];
  logic [7:0]  mid_b [2];
  logic [6:0]  fill_left [2];
  logic        final_due [2];
  logic        final_rep [2];
  logic [31:0] staged [2][epfg_pkg::MAX_CHANNELS];
  logic [31:0] ring_mem [2][epfg_pkg::RING_DEPTH];

  epfg_in_if  in_ch ();
  epfg_out_if out_ch ();
  epfg_cfg_if cfg_ch ();

  assign in_ch.valid   = src_valid;
  assign in_ch.opcode  = src_op;
  assign in_ch.rx_byte = src_byte;
  assign out_ch.ready  = sink_ready;
  assign cfg_ch.valid  = cfg_valid;
  assign cfg_ch.index  = cfg_index;
  assign cfg_ch.data   = cfg_data;

  eeg_packet_deframer_gap_fill u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  function automatic int active_channels();
    if (cc_val == 6'd0) return 1;
    if (int'(cc_val) > epfg_pkg::MAX_CHANNELS) return epfg_pkg::MAX_CHANNELS;
    return int'(cc_val);
  endfunction

  function automatic bit words_waiting(input int c);
    return (fill_left[c] != 7'd0) || final_due[c];
  endfunction

  function automatic chan_word_t deframe_step(input int c, input rx_item_t it);
    chan_word_t r;
    int n;
    int pos;
    r = '0;
    n = active_channels();
    if (it.op == epfg_pkg::OP_BYTE) begin
      if (words_waiting(c)) begin
        r.dropped = 1'b1;
      end else begin
        case (parse_ph[c])
          epfg_pkg::PH_SEEK: begin
            if (it.b == epfg_pkg::SYNC_BYTE) parse_ph[c] = epfg_pkg::PH_COUNTER;
          end
          epfg_pkg::PH_COUNTER: begin
            // The counter gap is taken modulo 128.
            fill_left[c] = 7'(it.b - last_cnt[c] - 8'd1);
            last_cnt[c] = it.b;
            chan_pos[c] = 0;
            grp_pos[c] = epfg_pkg::GRP_HIGH;
            parse_ph[c] = epfg_pkg::PH_DATA;
          end
          epfg_pkg::PH_DATA: begin
            if (grp_pos[c] == epfg_pkg::GRP_HIGH) begin
              hi_b[c] = it.b;
              grp_pos[c] = epfg_pkg::GRP_MID;
            end else if (grp_pos[c] == epfg_pkg::GRP_MID) begin
              mid_b[c] = it.b;
              grp_pos[c] = epfg_pkg::GRP_LOW;
            end else begin
              staged[c][chan_pos[c]] = (32'(hi_b[c]) << epfg_pkg::HI_SHIFT) |
                                       (32'(mid_b[c]) << epfg_pkg::MID_SHIFT) |
                                       (32'(it.b) << epfg_pkg::LO_SHIFT);
              grp_pos[c] = epfg_pkg::GRP_HIGH;
              chan_pos[c]++;
              if (chan_pos[c] >= n) parse_ph[c] = epfg_pkg::PH_STATUS;
            end
          end
          default: begin
            if (it.b == (strip_val ? epfg_pkg::STATUS_STRIP : epfg_pkg::STATUS_KEEP)) begin
              for (int i = 0; i < n; i++)
                ring_mem[c][slot_pos[c] * epfg_pkg::MAX_CHANNELS + i] = staged[c][i];
              final_rep[c] = 1'b0;
            end else begin
              final_rep[c] = 1'b1;
            end
            final_due[c] = 1'b1;
            emit_pos[c] = 0;
            parse_ph[c] = epfg_pkg::PH_SEEK;
          end
        endcase
      end
      r.more = words_waiting(c);
    end else if (words_waiting(c)) begin
      pos = slot_pos[c] * epfg_pkg::MAX_CHANNELS + emit_pos[c];
      r.carries = 1'b1;
      r.index = 5'(emit_pos[c]);
      r.last = (emit_pos[c] + 1 >= n);
      // Filler samples come out before the sample that closed the packet.
      if (fill_left[c] != 7'd0) begin
        r.kind = epfg_pkg::KIND_FILL;
        r.value = ring_mem[c][pos];
      end else if (final_rep[c]) begin
        r.kind = epfg_pkg::KIND_REPLAY;
        r.value = ring_mem[c][pos];
      end else begin
        r.kind = epfg_pkg::KIND_LIVE;
        r.value = staged[c][emit_pos[c]];
      end
      if (r.last) begin
        emit_pos[c] = 0;
        slot_pos[c] = (slot_pos[c] + 1 >= epfg_pkg::RING_SLOTS) ? 0 : slot_pos[c] + 1;
        if (fill_left[c] != 7'd0) fill_left[c] = fill_left[c] - 7'd1;
        else final_due[c] = 1'b0;
      end else begin
        emit_pos[c]++;
      end
      r.more = words_waiting(c);
    end
    return r;
  endfunction

  task automatic queue_item(input epfg_pkg::opcode_t op, input logic [7:0] b);
    rx_item_t it;
    it.op = op;
    it.b = b;
    void'(deframe_step(GEN_COPY, it));
    rx_items.push_back(it);
    item_count++;
  endtask

  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic int pick_gap(input int n);
    int r;
    r = $urandom_range(99);
    if (n <= 2 && r < 4) return $urandom_range(127);
    if (n <= 8 && r < 30) return $urandom_range(3, 1);
    if (r < 10) return 1;
    return 0;
  endfunction

  // Expects the generating copy to be hunting for sync with nothing queued.
  task automatic queue_packet(input int gap, input bit good_status, input bit cut_short);
    int stop_at;
    logic [7:0] good;
    logic [7:0] st;
    stop_at = 3 * active_channels();
    if (cut_short) stop_at = $urandom_range(stop_at - 1);
    good = strip_val ? epfg_pkg::STATUS_STRIP : epfg_pkg::STATUS_KEEP;
    queue_item(epfg_pkg::OP_BYTE, epfg_pkg::SYNC_BYTE);
    queue_item(epfg_pkg::OP_BYTE,
               8'(int'(last_cnt[GEN_COPY]) + 1 + gap + 128 * $urandom_range(1)));
    for (int i = 0; i < stop_at; i++) queue_item(epfg_pkg::OP_BYTE, pick_data());
    if (!cut_short) begin
      st = good;
      if (!good_status) begin
        if ($urandom_range(1) == 0) begin
          st = strip_val ? epfg_pkg::STATUS_KEEP : epfg_pkg::STATUS_STRIP;
        end else begin
          do st = 8'($urandom); while (st == good);
        end
      end
      queue_item(epfg_pkg::OP_BYTE, st);
    end
  endtask

  // Reads out every queued word and finishes any open packet, with the odd
  // byte thrown in while words wait so that it is dropped.
  task automatic settle();
    while (parse_ph[GEN_COPY] != epfg_pkg::PH_SEEK || words_waiting(GEN_COPY)) begin
      if (words_waiting(GEN_COPY)) begin
        if ($urandom_range(9) == 0) queue_item(epfg_pkg::OP_BYTE, 8'($urandom));
        else queue_item(epfg_pkg::OP_POLL, 8'($urandom));
      end else if (parse_ph[GEN_COPY] == epfg_pkg::PH_COUNTER) begin
        queue_item(epfg_pkg::OP_BYTE, last_cnt[GEN_COPY] + 8'd1);
      end else if (parse_ph[GEN_COPY] == epfg_pkg::PH_STATUS) begin
        queue_item(epfg_pkg::OP_BYTE,
                   strip_val ? epfg_pkg::STATUS_STRIP : epfg_pkg::STATUS_KEEP);
      end else begin
        queue_item(epfg_pkg::OP_BYTE, pick_data());
      end
    end
  endtask

  task automatic wait_idle();
    while (rx_items.size() != 0 || src_valid || exp_words.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [epfg_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= epfg_pkg::CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
    if (idx == epfg_pkg::REG_CHANNEL_COUNT) cc_val = 6'(val);
    else if (idx == epfg_pkg::REG_STRIP) strip_val = val[0];
  endtask

  task automatic run_phase(input int cc, input int strip, input int idle_pct,
                           input int stall_pct);
    int start;
    int pick;
    int n;
    wait_idle();
    write_reg(epfg_pkg::REG_CHANNEL_COUNT, cc);
    write_reg(epfg_pkg::REG_STRIP, strip);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = item_count;
    while (item_count - start < PHASE_LEN) begin
      pick = $urandom_range(99);
      n = active_channels();
      if (pick < 62) begin
        queue_packet(pick_gap(n), 1'b1, 1'b0);
      end else if (pick < 77) begin
        queue_packet(pick_gap(n), 1'b0, 1'b0);
      end else if (pick < 87) begin
        queue_packet(pick_gap(n), 1'b1, 1'b1);
        // On small packets a fresh sync lands in the middle of the broken one.
        if (n <= 4) queue_packet(0, 1'b1, 1'b0);
      end else if (pick < 95) begin
        repeat ($urandom_range(4, 1)) queue_item(epfg_pkg::OP_BYTE, 8'($urandom_range(254)));
      end else begin
        queue_item(epfg_pkg::OP_POLL, 8'($urandom));
      end
      settle();
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && in_ch.ready) exp_words.push_back(deframe_step(CHK_COPY, shown_item));
      if (!src_valid || in_ch.ready) begin
        if (rx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_item = rx_items.pop_front();
          src_valid <= 1'b1;
          src_op <= shown_item.op;
          src_byte <= shown_item.b;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    chan_word_t e;
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (exp_words.size() == 0) begin
          $error("result item arrived with nothing expected");
          err_count++;
        end else begin
          e = exp_words.pop_front();
          check_field("valid_res", e.carries, out_ch.valid_res);
          check_field("channel_value", e.value, out_ch.channel_value);
          check_field("channel_index", e.index, out_ch.channel_index);
          check_field("last_channel", e.last, out_ch.last_channel);
          check_field("sample_kind", e.kind, out_ch.sample_kind);
          check_field("more_pending", e.more, out_ch.more_pending);
          check_field("byte_dropped", e.dropped, out_ch.byte_dropped);
        end
      end
      sink_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    for (int c = 0; c < 2; c++) begin
      parse_ph[c] = epfg_pkg::PH_SEEK;
      last_cnt[c] = 8'd0;
      slot_pos[c] = 0;
      chan_pos[c] = 0;
      emit_pos[c] = 0;
      grp_pos[c] = epfg_pkg::GRP_HIGH;
      hi_b[c] = 8'd0;
      mid_b[c] = 8'd0;
      fill_left[c] = 7'd0;
      final_due[c] = 1'b0;
      final_rep[c] = 1'b0;
      for (int i = 0; i < epfg_pkg::MAX_CHANNELS; i++) staged[c][i] = '0;
      for (int i = 0; i < epfg_pkg::RING_DEPTH; i++) ring_mem[c][i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on one-channel packets.
    write_reg(epfg_pkg::REG_CHANNEL_COUNT, 1);
    write_reg(epfg_pkg::REG_STRIP, 0);
    queue_item(epfg_pkg::OP_POLL, 8'h00);
    queue_item(epfg_pkg::OP_BYTE, 8'h3C);
    queue_item(epfg_pkg::OP_BYTE, epfg_pkg::SYNC_BYTE);
    queue_item(epfg_pkg::OP_BYTE, 8'h01);
    repeat (3) queue_item(epfg_pkg::OP_BYTE, 8'hFF);
    queue_item(epfg_pkg::OP_BYTE, epfg_pkg::STATUS_KEEP);
    queue_item(epfg_pkg::OP_BYTE, 8'h00);
    queue_item(epfg_pkg::OP_POLL, 8'hFF);
    // A counter jump of three leaves two filler samples, then a bad status.
    queue_item(epfg_pkg::OP_BYTE, epfg_pkg::SYNC_BYTE);
    queue_item(epfg_pkg::OP_BYTE, 8'h04);
    repeat (3) queue_item(epfg_pkg::OP_BYTE, 8'h00);
    queue_item(epfg_pkg::OP_BYTE, epfg_pkg::STATUS_STRIP);
    repeat (3) queue_item(epfg_pkg::OP_POLL, 8'h5A);
    // The top counter bit does not count towards the gap.
    queue_item(epfg_pkg::OP_BYTE, epfg_pkg::SYNC_BYTE);
    queue_item(epfg_pkg::OP_BYTE, 8'h85);
    queue_item(epfg_pkg::OP_BYTE, 8'h80);
    queue_item(epfg_pkg::OP_BYTE, 8'h01);
    queue_item(epfg_pkg::OP_BYTE, 8'h7F);
    queue_item(epfg_pkg::OP_BYTE, epfg_pkg::STATUS_KEEP);
    queue_item(epfg_pkg::OP_POLL, 8'hA5);

    run_phase(3, 1, 0, 0);
    run_phase(0, 0, 78, 0);
    run_phase(32, 1, 0, 78);
    run_phase(2, 0, 27, 27);
    run_phase(63, 1, 0, 0);
    run_phase(5, 0, 78, 0);
    run_phase(1, 1, 0, 78);
    run_phase(4, 0, 27, 27);
    wait_idle();

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
